[hdl/spmv_pkg.sv]
// shared constants and types for the sync packet majority vote receiver
`default_nettype none
package spmv_pkg;

  localparam int SAMPLES = 10;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CNT_W   = $clog2(SAMPLES + 1);

  localparam logic [BYTE_W-1:0] NO_MAJORITY = 8'd255;
  localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'b11110101;
  localparam logic [BYTE_W-1:0] AREA_RESET  = 8'd200;

  localparam int CFG_IDX_W  = 1;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_VALUE = 1'b0,
    REG_AREA_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              data_en;
    logic              sync_en;
    logic [BYTE_W-1:0] rx_byte;
  } store_cmd_t;

  typedef struct packed {
    logic             sel_y;
    logic [IDX_W-1:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] vote_x;
    logic [BYTE_W-1:0] vote_y;
  } vote_status_t;

endpackage
`default_nettype wire

[hdl/spmv_store.sv]
// x and y sample stores with the packet fill sequencing
`default_nettype none
module spmv_store
  import spmv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire store_cmd_t        cmd,
  input  wire rd_req_t           rd_req,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] x_store_r [SAMPLES];
  logic [BYTE_W-1:0] y_store_r [SAMPLES];
  logic              in_y_phase_r, in_y_phase_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              wr_x, wr_y;

  always_comb begin
    in_y_phase_nxt = in_y_phase_r;
    fill_nxt       = fill_r;
    wr_x           = 1'b0;
    wr_y           = 1'b0;
    if (cmd.sync_en) begin
      in_y_phase_nxt = 1'b0;
      fill_nxt       = '0;
    end else if (cmd.data_en) begin
      if (!in_y_phase_r) begin
        wr_x = (fill_r < CNT_W'(SAMPLES));
        if (fill_r >= CNT_W'(SAMPLES - 1)) begin
          in_y_phase_nxt = 1'b1;
          fill_nxt       = '0;
        end else begin
          fill_nxt = CNT_W'(fill_r + 1'b1);
        end
      end else if (fill_r < CNT_W'(SAMPLES)) begin
        wr_y     = 1'b1;
        fill_nxt = CNT_W'(fill_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_y_phase_r <= 1'b0;
      fill_r       <= '0;
      for (int i = 0; i < SAMPLES; i++) begin
        x_store_r[i] <= '0;
        y_store_r[i] <= '0;
      end
    end else begin
      in_y_phase_r <= in_y_phase_nxt;
      fill_r       <= fill_nxt;
      if (wr_x) x_store_r[fill_r[IDX_W-1:0]] <= cmd.rx_byte;
      if (wr_y) y_store_r[fill_r[IDX_W-1:0]] <= cmd.rx_byte;
    end
  end

  assign rd_data = rd_req.sel_y ? y_store_r[rd_req.idx] : x_store_r[rd_req.idx];

endmodule
`default_nettype wire

[hdl/spmv_vote.sv]
// sequencer and shared compare and count unit for the majority vote
`default_nettype none
module spmv_vote
  import spmv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              ack,
  output rd_req_t                rd_req,
  input  wire logic [BYTE_W-1:0] rd_data,
  output vote_status_t           status
);

  typedef enum logic [4:0] {
    V_IDLE  = 5'b00001,
    V_LOAD  = 5'b00010,
    V_COUNT = 5'b00100,
    V_JUDGE = 5'b01000,
    V_DONE  = 5'b10000
  } vote_state_t;

  vote_state_t       state_r, state_nxt;
  logic              sel_y_r, sel_y_nxt;
  logic [IDX_W-1:0]  a_r, a_nxt;
  logic [IDX_W-1:0]  b_r, b_nxt;
  logic [BYTE_W-1:0] cand_r, cand_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic [BYTE_W-1:0] best_val_r, best_val_nxt;
  logic [BYTE_W-1:0] vote_x_r, vote_x_nxt;
  logic [BYTE_W-1:0] vote_y_r, vote_y_nxt;
  logic              better;
  logic [BYTE_W-1:0] winner;

  assign rd_req.sel_y = sel_y_r;
  assign rd_req.idx   = (state_r == V_LOAD) ? a_r : b_r;

  assign better = cnt_r > best_cnt_r;
  always_comb begin
    logic [CNT_W-1:0]  fin_cnt;
    logic [BYTE_W-1:0] fin_val;
    fin_cnt = better ? cnt_r : best_cnt_r;
    fin_val = better ? cand_r : best_val_r;
    winner  = (fin_cnt > CNT_W'(SAMPLES / 2)) ? fin_val : NO_MAJORITY;
  end

  always_comb begin
    state_nxt    = state_r;
    sel_y_nxt    = sel_y_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    cand_nxt     = cand_r;
    cnt_nxt      = cnt_r;
    best_cnt_nxt = best_cnt_r;
    best_val_nxt = best_val_r;
    vote_x_nxt   = vote_x_r;
    vote_y_nxt   = vote_y_r;
    unique case (state_r)
      V_IDLE: begin
        if (start) begin
          state_nxt    = V_LOAD;
          sel_y_nxt    = 1'b0;
          a_nxt        = '0;
          best_cnt_nxt = '0;
          best_val_nxt = '0;
        end
      end
      V_LOAD: begin
        cand_nxt  = rd_data;
        b_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = V_COUNT;
      end
      V_COUNT: begin
        if (rd_data == cand_r) cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (b_r == IDX_W'(SAMPLES - 1)) begin
          state_nxt = V_JUDGE;
        end else begin
          b_nxt = IDX_W'(b_r + 1'b1);
        end
      end
      V_JUDGE: begin
        if (better) begin
          best_cnt_nxt = cnt_r;
          best_val_nxt = cand_r;
        end
        if (a_r == IDX_W'(SAMPLES - 1)) begin
          if (!sel_y_r) begin
            vote_x_nxt   = winner;
            sel_y_nxt    = 1'b1;
            a_nxt        = '0;
            best_cnt_nxt = '0;
            best_val_nxt = '0;
            state_nxt    = V_LOAD;
          end else begin
            vote_y_nxt = winner;
            state_nxt  = V_DONE;
          end
        end else begin
          a_nxt     = IDX_W'(a_r + 1'b1);
          state_nxt = V_LOAD;
        end
      end
      V_DONE: begin
        if (ack) state_nxt = V_IDLE;
      end
      default: state_nxt = V_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= V_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_y_r    <= sel_y_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    cand_r     <= cand_nxt;
    cnt_r      <= cnt_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_val_r <= best_val_nxt;
    vote_x_r   <= vote_x_nxt;
    vote_y_r   <= vote_y_nxt;
  end

  assign status.busy   = (state_r != V_IDLE);
  assign status.done   = (state_r == V_DONE);
  assign status.vote_x = vote_x_r;
  assign status.vote_y = vote_y_r;

  // matches counted so far never exceed the entries compared
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == V_COUNT) |-> (cnt_r <= CNT_W'(b_r)))
    else $error("match count ahead of compare index");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == V_IDLE))
    else $error("vote started while busy");

  a_count_to_judge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == V_JUDGE) |-> $past(state_r == V_COUNT && b_r == IDX_W'(SAMPLES - 1)))
    else $error("judge reached before full count");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == V_DONE && !ack) |=> (state_r == V_DONE && $stable(vote_x_r)
      && $stable(vote_y_r)))
    else $error("vote result lost before transfer");

endmodule
`default_nettype wire

[hdl/sync_packet_majority_vote_receiver.sv]
// top level: stream ports, configuration, held position and result register
// Takes one received byte per transfer. Data bytes fill the X then the Y sample
// store; a byte equal to sync_value restarts the fill and runs a majority vote
// over both stores, giving one result transfer. A data byte is taken whenever
// no vote is running. A sync byte keeps the input not ready while the single
// shared compare and count unit runs the vote, comparing one stored pair per
// cycle as it counts, plus any wait for the result register to be free.
// Configuration writes are taken at any time.
`default_nettype none
module sync_packet_majority_vote_receiver
  import spmv_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // rx_byte[7:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // vote_x[7:0], vote_y[15:8], accepted[16], held_x[24:17], held_y[32:25]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_wdata
);

  logic [BYTE_W-1:0] sync_value_r, area_limit_r;
  logic [BYTE_W-1:0] pos_x_r, pos_y_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_vx_r, out_vy_r, out_hx_r, out_hy_r;
  logic              out_ok_r;

  store_cmd_t        cmd;
  rd_req_t           rd_req;
  logic [BYTE_W-1:0] rd_data;
  vote_status_t      status;
  logic              in_xfer, is_sync, load_out, ok;

  assign in_tready = !status.busy;
  assign in_xfer   = in_tvalid && in_tready;
  assign is_sync   = (in_tdata == sync_value_r);

  assign cmd.sync_en = in_xfer && is_sync;
  assign cmd.data_en = in_xfer && !is_sync;
  assign cmd.rx_byte = in_tdata;

  assign load_out = status.done && (!out_valid_r || out_tready);
  assign ok = (status.vote_x <= area_limit_r) && (status.vote_y <= area_limit_r);

  spmv_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  spmv_vote u_vote (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sync_en),
    .ack     (load_out),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .status  (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= SYNC_RESET;
      area_limit_r <= AREA_RESET;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SYNC_VALUE: sync_value_r <= cfg_wdata;
          REG_AREA_LIMIT: area_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (load_out && ok) begin
        pos_x_r <= status.vote_x;
        pos_y_r <= status.vote_y;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_vx_r <= status.vote_x;
      out_vy_r <= status.vote_y;
      out_ok_r <= ok;
      out_hx_r <= ok ? status.vote_x : pos_x_r;
      out_hy_r <= ok ? status.vote_y : pos_y_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_hy_r, out_hx_r, out_ok_r, out_vy_r, out_vx_r};

  // an accepted vote must be what the held position now shows
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ok_r) |-> (out_hx_r == out_vx_r && out_hy_r == out_vy_r
      && pos_x_r == out_vx_r && pos_y_r == out_vy_r))
    else $error("held position differs from accepted vote");

endmodule
`default_nettype wire
